// ===== sv/auc_pkg.sv =====
// ----------------------------------------------------------------------------
// auc_pkg
// shared widths for the rank-sum area under curve block
// ----------------------------------------------------------------------------
`default_nettype none

package auc_pkg;

    localparam int LABEL_W = 16;
    localparam int AUC_W   = 17;
    localparam int FRAC_W  = 16;

    // divider handshake between the top level and the divide unit
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

// ===== sv/auc_rank_sum.sv =====
// ----------------------------------------------------------------------------
// auc_rank_sum
// roc area under curve by rank sum over a loaded set of scored items
// ----------------------------------------------------------------------------
// channel  signals                                    transfer
// in       label_value, prediction, last_item         in_valid & in_ready
// out      auc_value, degenerate, overflowed          out_valid & out_ready
//
// items load one per cycle into a record ram. after the last item the set is
// merge sorted between two rams, one run pair at a time, then walked to count
// positives and negatives, then divided unless either count is zero, which
// marks the result degenerate. in_ready is
// low from the last item until the result sits in the output register.
// no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module auc_rank_sum
    import auc_pkg::*;
#(
    parameter int MAX_ITEMS   = 1024,
    parameter int SCORE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [LABEL_W-1:0]     label_value,
    input  wire logic [SCORE_WIDTH-1:0] prediction,
    input  wire logic                   last_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [AUC_W-1:0]       auc_value,
    output logic                        degenerate,
    output logic                        overflowed
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W = CNT_W + 2;
    localparam int TOT_W = LABEL_W + CNT_W;
    localparam int PR_W  = 2 * CNT_W;
    localparam int DVD_W = PR_W + FRAC_W + 1;
    localparam int REC_W = SCORE_WIDTH + LABEL_W;

    typedef enum logic [11:0] {
        ST_LOAD = 12'b000000000001,
        ST_RUN  = 12'b000000000010,
        ST_FA   = 12'b000000000100,
        ST_FB   = 12'b000000001000,
        ST_MRG  = 12'b000000010000,
        ST_MW   = 12'b000000100000,
        ST_WRD  = 12'b000001000000,
        ST_WCAP = 12'b000010000000,
        ST_PROD = 12'b000100000000,
        ST_FOLD = 12'b001000000000,
        ST_DIV  = 12'b010000000000,
        ST_OUT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             src_reg, src_next;
    logic [CNT_W:0]   w_reg, w_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             side_reg, side_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] neg_reg, neg_next;
    logic [PR_W-1:0]  sum_reg, sum_next;
    logic [PR_W-1:0]  prod_reg, prod_next;
    logic [REC_W-1:0] ha_reg, ha_next;
    logic [REC_W-1:0] hb_reg, hb_next;
    logic [AUC_W-1:0] res_auc_reg, res_auc_next;
    logic             res_deg_reg, res_deg_next;
    logic             out_valid_reg, out_valid_next;
    logic [AUC_W-1:0] auc_reg, auc_next;
    logic             deg_reg, deg_next;
    logic             ovo_reg, ovo_next;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;
    logic             load_wr;
    logic             merge_wr;
    logic [REC_W-1:0] rd0, rd1, rd_rec;

    logic [EXT_W-1:0] ext_mid, ext_hi, ext_lo2;
    logic             a_ok, b_ok, take_a;
    logic             accept;
    logic [TOT_W-1:0] lab_prod;
    logic [PR_W-1:0]  diff, num;
    logic [DVD_W-1:0] dividend;
    div_ctl_t         div_ctl;
    div_sts_t         div_sts;
    logic [DVD_W-1:0] quotient;

    assign rd_rec = src_reg ? rd1 : rd0;
    assign accept = in_valid && in_ready;

    auc_ram #(.WIDTH(REC_W), .DEPTH(MAX_ITEMS)) u_ram0 (
        .clk     (clk),
        .wr_en   (load_wr || (merge_wr && src_reg)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd0)
    );

    auc_ram #(.WIDTH(REC_W), .DEPTH(MAX_ITEMS)) u_ram1 (
        .clk     (clk),
        .wr_en   (merge_wr && !src_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd1)
    );

    auc_div #(.DVD_W(DVD_W), .DVS_W(PR_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (dividend),
        .divisor  (prod_reg),
        .sts      (div_sts),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tot_next       = tot_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        src_next       = src_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        side_next      = side_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        res_auc_next   = res_auc_reg;
        res_deg_next   = res_deg_reg;
        out_valid_next = out_valid_reg;
        auc_next       = auc_reg;
        deg_next       = deg_reg;
        ovo_next       = ovo_reg;
        rd_addr        = '0;
        wr_addr        = k_reg[IDX_W-1:0];
        load_wr        = 1'b0;
        merge_wr       = 1'b0;
        div_ctl.start  = 1'b0;
        in_ready       = (state_reg == ST_LOAD);

        ext_mid = EXT_W'(lo_reg) + EXT_W'(w_reg);
        if (ext_mid > EXT_W'(n_reg))
        begin
            ext_mid = EXT_W'(n_reg);
        end
        ext_hi = EXT_W'(lo_reg) + EXT_W'({w_reg, 1'b0});
        ext_lo2 = ext_hi;
        if (ext_hi > EXT_W'(n_reg))
        begin
            ext_hi = EXT_W'(n_reg);
        end
        a_ok   = a_reg < mid_reg;
        b_ok   = b_reg < hi_reg;
        take_a = a_ok && (!b_ok ||
                 ($signed(ha_reg[REC_W-1:LABEL_W]) >= $signed(hb_reg[REC_W-1:LABEL_W])));
        wr_data  = take_a ? ha_reg : hb_reg;
        lab_prod = TOT_W'(rd_rec[LABEL_W-1:0]) * TOT_W'(n_reg);
        diff = prod_reg - sum_reg;
        num  = (sum_reg > diff) ? sum_reg : diff;
        dividend = {1'b0, num, {FRAC_W{1'b0}}} + DVD_W'(prod_reg >> 1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    wr_addr = cnt_reg[IDX_W-1:0];
                    wr_data = {prediction, label_value};
                    if (cnt_reg < CNT_W'(MAX_ITEMS))
                    begin
                        load_wr  = 1'b1;
                        tot_next = tot_reg + TOT_W'(label_value);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        n_next   = cnt_next;
                        src_next = 1'b0;
                        w_next   = (CNT_W+1)'(1);
                        lo_next  = '0;
                        i_next   = '0;
                        pos_next = '0;
                        neg_next = '0;
                        sum_next = '0;
                        state_next = (cnt_next == CNT_W'(1)) ? ST_WRD : ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                mid_next = ext_mid[CNT_W-1:0];
                hi_next  = ext_hi[CNT_W-1:0];
                a_next   = lo_reg;
                b_next   = ext_mid[CNT_W-1:0];
                k_next   = lo_reg;
                rd_addr  = lo_reg[IDX_W-1:0];
                state_next = ST_FA;
            end
            ST_FA:
            begin
                ha_next = rd_rec;
                rd_addr = mid_reg[IDX_W-1:0];
                state_next = ST_FB;
            end
            ST_FB:
            begin
                hb_next = rd_rec;
                state_next = ST_MRG;
            end
            ST_MRG:
            begin
                if (!a_ok && !b_ok)
                begin
                    // this run pair is merged, move to the next pair or pass
                    if (ext_lo2 >= EXT_W'(n_reg))
                    begin
                        lo_next  = '0;
                        w_next   = {w_reg[CNT_W-1:0], 1'b0};
                        src_next = !src_reg;
                        state_next = ({w_reg[CNT_W-1:0], 1'b0} >= (CNT_W+1)'(n_reg)) ?
                                     ST_WRD : ST_RUN;
                    end
                    else
                    begin
                        lo_next = ext_lo2[CNT_W-1:0];
                        state_next = ST_RUN;
                    end
                end
                else
                begin
                    merge_wr = 1'b1;
                    k_next   = k_reg + 1'b1;
                    if (take_a)
                    begin
                        a_next    = a_reg + 1'b1;
                        rd_addr   = IDX_W'(a_reg + 1'b1);
                        side_next = 1'b0;
                    end
                    else
                    begin
                        b_next    = b_reg + 1'b1;
                        rd_addr   = IDX_W'(b_reg + 1'b1);
                        side_next = 1'b1;
                    end
                    state_next = ST_MW;
                end
            end
            ST_MW:
            begin
                if (side_reg)
                begin
                    hb_next = rd_rec;
                end
                else
                begin
                    ha_next = rd_rec;
                end
                state_next = ST_MRG;
            end
            ST_WRD:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                state_next = (i_reg == n_reg) ? ST_PROD : ST_WCAP;
            end
            ST_WCAP:
            begin
                // positive only when strictly above the mean
                if (lab_prod > tot_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                    sum_next = sum_reg + PR_W'(neg_reg);
                end
                else
                begin
                    neg_next = neg_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                state_next = ST_WRD;
            end
            ST_PROD:
            begin
                prod_next = PR_W'(pos_reg) * PR_W'(neg_reg);
                if (pos_reg == '0 || neg_reg == '0)
                begin
                    res_auc_next = '0;
                    res_deg_next = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    res_deg_next = 1'b0;
                    state_next   = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                div_ctl.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    res_auc_next = quotient[AUC_W-1:0];
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    auc_next = res_auc_reg;
                    deg_next = res_deg_reg;
                    ovo_next = ovf_reg;
                    cnt_next = '0;
                    tot_next = '0;
                    ovf_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            tot_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tot_reg       <= tot_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        src_reg     <= src_next;
        w_reg       <= w_next;
        lo_reg      <= lo_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        side_reg    <= side_next;
        i_reg       <= i_next;
        pos_reg     <= pos_next;
        neg_reg     <= neg_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        ha_reg      <= ha_next;
        hb_reg      <= hb_next;
        res_auc_reg <= res_auc_next;
        res_deg_reg <= res_deg_next;
        auc_reg     <= auc_next;
        deg_reg     <= deg_next;
        ovo_reg     <= ovo_next;
    end

    assign out_valid  = out_valid_reg;
    assign auc_value  = auc_reg;
    assign degenerate = deg_reg;
    assign overflowed = ovo_reg;

endmodule

`default_nettype wire

// ===== sv/auc_ram.sv =====
// ----------------------------------------------------------------------------
// auc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module auc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/auc_div.sv =====
// ----------------------------------------------------------------------------
// auc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module auc_div
    import auc_pkg::*;
#(
    parameter int DVD_W = 51,
    parameter int DVS_W = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_ctl_t         ctl,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_sts_t              sts,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W+1:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (ctl.start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, dvs_reg})
            begin
                trial = trial - {2'b00, dvs_reg};
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            // remainder stays below the divisor
            rem_next = trial[DVS_W:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign sts.done = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire
